/* src/railroad_car_rearranger_macros.svh */
// ---------------------------------------------------------------------------
// Railroad car rearranger assertion macros
// Shared concurrent assertion wrappers on clk_i, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef RAILROAD_CAR_REARRANGER_MACROS_SVH
`define RAILROAD_CAR_REARRANGER_MACROS_SVH

// Check a property while out of reset.
`define RCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/rcr_pkg.sv */
// ---------------------------------------------------------------------------
// Railroad car rearranger package
// Widths, codes and payload types shared by the controller, memory and top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcr_pkg;

  localparam int MAX_TRACKS = 8;
  localparam int MAX_CARS   = 64;

  localparam int CAR_W     = 7;
  localparam int TRK_W     = 4;
  localparam int TRK_IDX_W = $clog2(MAX_TRACKS);
  localparam int TRK_CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int ENT_W     = $clog2(MAX_CARS);
  localparam int FILL_W    = $clog2(MAX_CARS + 1);
  localparam int ADDR_W    = TRK_IDX_W + ENT_W;
  localparam int MEM_DEPTH = MAX_TRACKS * MAX_CARS;

  // Marker for "no car held": above every legal car number.
  localparam logic [CAR_W-1:0] NONE_HELD = CAR_W'(MAX_CARS + 2);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CARS   = 1'd1;

  typedef enum logic [1:0] {
    STAT_MOVED    = 2'd0,
    STAT_NO_TRACK = 2'd1,
    STAT_FAILED   = 2'd2,
    STAT_RANGE    = 2'd3
  } rcr_status_e;

  typedef struct packed {
    logic [CAR_W-1:0] car;
    logic             new_sequence;
  } rcr_in_t;

  typedef struct packed {
    logic [CAR_W-1:0] moved_car;
    logic [TRK_W-1:0] from_track;
    logic [TRK_W-1:0] to_track;
    rcr_status_e      status;
    logic             last;
  } rcr_out_t;

  // Clamped configuration as the controller sees it.
  typedef struct packed {
    logic [TRK_W-1:0] ntr;
    logic [CAR_W-1:0] ncar;
  } rcr_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CAR_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } rcr_mem_req_t;

endpackage

/* src/rcr_track_mem.sv */
// ---------------------------------------------------------------------------
// Holding track store
// One row of MAX_CARS entries per track; one write and one registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcr_track_mem import rcr_pkg::*; (
  input  logic               clk_i,
  input  rcr_mem_req_t       req_i,
  output logic [CAR_W-1:0]   rdata_o
);

  logic [CAR_W-1:0] mem_q [MEM_DEPTH];
  logic [CAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rcr_ctrl.sv */
// ---------------------------------------------------------------------------
// Railroad car rearranger controller
// Decides each car, scans track tops out of the store, pushes and releases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcr_ctrl import rcr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  rcr_in_t          item_i,
  input  rcr_cfg_t         cfg_i,
  output logic             result_strobe_o,
  output rcr_out_t         result_o,
  output rcr_mem_req_t     mem_req_o,
  input  logic [CAR_W-1:0] mem_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_PARK,
    S_REL
  } state_e;

  state_e               state_q;
  logic [FILL_W-1:0]    fill_q [MAX_TRACKS];
  logic [CAR_W-1:0]     next_out_q;
  logic [CAR_W-1:0]     small_car_q;
  logic [TRK_W-1:0]     small_trk_q;
  logic                 failed_q;
  logic [CAR_W-1:0]     car_q;
  logic [TRK_CNT_W-1:0] cnt_q;
  logic [TRK_CNT_W-1:0] lim_q;
  logic                 ev_v_q;
  logic [TRK_IDX_W-1:0] ev_idx_q;
  logic [CAR_W-1:0]     acc_car_q;
  logic [TRK_W-1:0]     acc_trk_q;
  logic [CAR_W-1:0]     rel_car_q;
  logic [TRK_W-1:0]     rel_trk_q;
  logic                 strobe_q;
  rcr_out_t             result_q;

  logic [MAX_TRACKS-1:0] live;
  logic [TRK_IDX_W-1:0]  cnt_idx;
  logic [FILL_W-1:0]     fill_m1;
  logic                  scanning;
  logic                  issue;
  logic                  scan_done;
  logic [FILL_W-1:0]     ev_fill;
  logic [TRK_W-1:0]      ev_trk;
  logic [CAR_W-1:0]      acc_car_nx;
  logic [TRK_W-1:0]      acc_trk_nx;
  logic [TRK_W-1:0]      best_m1;
  logic [TRK_IDX_W-1:0]  best_idx;
  logic [TRK_W-1:0]      small_m1;
  logic [TRK_IDX_W-1:0]  small_idx;
  logic [CAR_W-1:0]      next_p1;
  logic                  out_of_range;
  logic                  rel_first;
  logic                  rel_again;

  function automatic logic rel_ok(input logic [CAR_W-1:0]      sc,
                                  input logic [TRK_W-1:0]      st,
                                  input logic [CAR_W-1:0]      nxt,
                                  input logic [MAX_TRACKS-1:0] lv);
    logic [TRK_W-1:0] st_m1;
    st_m1 = st - TRK_W'(1);
    return (sc == nxt) && (st != '0) && (st <= TRK_W'(MAX_TRACKS)) &&
           lv[st_m1[TRK_IDX_W-1:0]];
  endfunction

  function automatic rcr_out_t mk_rec(input logic [CAR_W-1:0] c,
                                      input logic [TRK_W-1:0] f,
                                      input logic [TRK_W-1:0] t,
                                      input rcr_status_e      s,
                                      input logic             l);
    rcr_out_t r;
    r.moved_car  = c;
    r.from_track = f;
    r.to_track   = t;
    r.status     = s;
    r.last       = l;
    return r;
  endfunction

  always_comb begin
    for (int t = 0; t < MAX_TRACKS; t++) begin
      live[t] = (fill_q[t] != '0);
    end
  end

  // Read one track top per cycle; the store returns it in the next cycle.
  assign cnt_idx   = cnt_q[TRK_IDX_W-1:0];
  assign fill_m1   = fill_q[cnt_idx] - FILL_W'(1);
  assign scanning  = (state_q == S_PARK) || (state_q == S_REL);
  assign issue     = scanning && (cnt_q < lim_q);
  assign scan_done = ev_v_q && (cnt_q == lim_q);
  assign ev_fill   = fill_q[ev_idx_q];
  assign ev_trk    = TRK_W'(ev_idx_q) + TRK_W'(1);

  always_comb begin
    acc_car_nx = acc_car_q;
    acc_trk_nx = acc_trk_q;
    if (ev_v_q) begin
      if (ev_fill != '0) begin
        if (state_q == S_PARK) begin
          if ((car_q < mem_rdata_i) && (mem_rdata_i < acc_car_q) &&
              (ev_fill < FILL_W'(MAX_CARS))) begin
            acc_car_nx = mem_rdata_i;
            acc_trk_nx = ev_trk;
          end
        end else if (mem_rdata_i < acc_car_q) begin
          acc_car_nx = mem_rdata_i;
          acc_trk_nx = ev_trk;
        end
      end else if ((state_q == S_PARK) && (acc_trk_q == '0)) begin
        // Take the first empty track unless a fitting top turns up later.
        acc_trk_nx = ev_trk;
      end
    end
  end

  assign best_m1      = acc_trk_nx - TRK_W'(1);
  assign best_idx     = best_m1[TRK_IDX_W-1:0];
  assign small_m1     = small_trk_q - TRK_W'(1);
  assign small_idx    = small_m1[TRK_IDX_W-1:0];
  assign next_p1      = next_out_q + CAR_W'(1);
  assign out_of_range = (car_q == '0) || (car_q > cfg_i.ncar) || (car_q < next_out_q);
  assign rel_first    = rel_ok(small_car_q, small_trk_q, next_p1, live);
  assign rel_again    = rel_ok(acc_car_nx, acc_trk_nx, next_out_q, live);

  always_comb begin
    mem_req_o.re    = issue;
    mem_req_o.raddr = {cnt_idx, fill_m1[ENT_W-1:0]};
    mem_req_o.we    = (state_q == S_PARK) && scan_done && (acc_trk_nx != '0);
    mem_req_o.waddr = {best_idx, fill_q[best_idx][ENT_W-1:0]};
    mem_req_o.wdata = car_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int t = 0; t < MAX_TRACKS; t++) begin
        fill_q[t] <= '0;
      end
      next_out_q  <= CAR_W'(1);
      small_car_q <= NONE_HELD;
      small_trk_q <= '0;
      failed_q    <= 1'b0;
      car_q       <= '0;
      cnt_q       <= '0;
      lim_q       <= '0;
      ev_v_q      <= 1'b0;
      ev_idx_q    <= '0;
      acc_car_q   <= NONE_HELD;
      acc_trk_q   <= '0;
      rel_car_q   <= '0;
      rel_trk_q   <= '0;
      strobe_q    <= 1'b0;
      result_q    <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            car_q <= item_i.car;
            if (item_i.new_sequence) begin
              for (int t = 0; t < MAX_TRACKS; t++) begin
                fill_q[t] <= '0;
              end
              next_out_q  <= CAR_W'(1);
              small_car_q <= NONE_HELD;
              small_trk_q <= '0;
              failed_q    <= 1'b0;
            end
            state_q <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          cnt_q     <= '0;
          ev_v_q    <= 1'b0;
          acc_car_q <= NONE_HELD;
          acc_trk_q <= '0;
          priority if (failed_q) begin
            strobe_q <= 1'b1;
            result_q <= mk_rec('0, '0, '0, STAT_FAILED, 1'b1);
            state_q  <= S_IDLE;
          end else if (out_of_range) begin
            strobe_q <= 1'b1;
            result_q <= mk_rec('0, '0, '0, STAT_RANGE, 1'b1);
            state_q  <= S_IDLE;
          end else if (car_q == next_out_q) begin
            strobe_q <= 1'b1;
            result_q <= mk_rec(car_q, '0, '0, STAT_MOVED, !rel_first);
            if (rel_first) begin
              // Pop the held car now; its record goes out after the rescan.
              fill_q[small_idx] <= fill_q[small_idx] - FILL_W'(1);
              rel_car_q         <= small_car_q;
              rel_trk_q         <= small_trk_q;
              next_out_q        <= next_out_q + CAR_W'(2);
              lim_q             <= TRK_CNT_W'(MAX_TRACKS);
              state_q           <= S_REL;
            end else begin
              next_out_q <= next_p1;
              state_q    <= S_IDLE;
            end
          end else begin
            lim_q   <= TRK_CNT_W'(cfg_i.ntr);
            state_q <= S_PARK;
          end
        end

        S_PARK: begin
          if (scan_done) begin
            strobe_q <= 1'b1;
            if (acc_trk_nx == '0) begin
              failed_q <= 1'b1;
              result_q <= mk_rec('0, '0, '0, STAT_NO_TRACK, 1'b1);
            end else begin
              fill_q[best_idx] <= fill_q[best_idx] + FILL_W'(1);
              if (car_q < small_car_q) begin
                small_car_q <= car_q;
                small_trk_q <= acc_trk_nx;
              end
              result_q <= mk_rec(car_q, '0, acc_trk_nx, STAT_MOVED, 1'b1);
            end
            state_q <= S_IDLE;
          end else begin
            acc_car_q <= acc_car_nx;
            acc_trk_q <= acc_trk_nx;
            ev_v_q    <= issue;
            ev_idx_q  <= cnt_idx;
            if (issue) begin
              cnt_q <= cnt_q + TRK_CNT_W'(1);
            end
          end
        end

        S_REL: begin
          if (scan_done) begin
            small_car_q <= acc_car_nx;
            small_trk_q <= acc_trk_nx;
            strobe_q    <= 1'b1;
            result_q    <= mk_rec(rel_car_q, rel_trk_q, '0, STAT_MOVED, !rel_again);
            if (rel_again) begin
              fill_q[best_idx] <= fill_q[best_idx] - FILL_W'(1);
              rel_car_q        <= acc_car_nx;
              rel_trk_q        <= acc_trk_nx;
              next_out_q       <= next_p1;
              cnt_q            <= '0;
              ev_v_q           <= 1'b0;
              acc_car_q        <= NONE_HELD;
              acc_trk_q        <= '0;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            acc_car_q <= acc_car_nx;
            acc_trk_q <= acc_trk_nx;
            ev_v_q    <= issue;
            ev_idx_q  <= cnt_idx;
            if (issue) begin
              cnt_q <= cnt_q + TRK_CNT_W'(1);
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

endmodule

/* src/railroad_car_rearranger.sv */
// ---------------------------------------------------------------------------
// Railroad car rearranger
// Parks incoming cars on holding tracks and delivers them to the output in
// order, one move record per strobe.
// ---------------------------------------------------------------------------
// A car is taken when start is high and busy is low. The block answers with
// one or more move records, each valid for exactly one cycle under
// result_strobe_o, the final one of a car marked by last; the receiver must
// take every beat as it comes. A car that goes straight out is settled in the
// decide state, a car that is parked scans the top of each configured track,
// and each held car released behind it rescans all MAX_TRACKS tracks: every
// track top sits in the track store and is read back one track per cycle
// through its single read port before the choice is settled. The final record
// shows in the first cycle with busy low, so the next car may start there.
// Configuration writes belong to idle periods only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "railroad_car_rearranger_macros.svh"

module railroad_car_rearranger import rcr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rcr_in_t              item_i,
  output logic                 result_strobe_o,
  output rcr_out_t             result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CAR_W-1:0]     cfg_wdata_i
);

  logic [TRK_W-1:0] tracks_q;
  logic [CAR_W-1:0] cars_q;
  rcr_cfg_t         cfg;
  rcr_mem_req_t     mem_req;
  logic [CAR_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracks_q <= TRK_W'(3);
      cars_q   <= CAR_W'(MAX_CARS);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TRACKS: tracks_q <= cfg_wdata_i[TRK_W-1:0];
        CFG_CARS:   cars_q   <= cfg_wdata_i;
        default:    tracks_q <= tracks_q;
      endcase
    end
  end

  // Clamp the registers into their legal ranges.
  always_comb begin
    cfg.ntr = tracks_q;
    if (tracks_q == '0) begin
      cfg.ntr = TRK_W'(1);
    end else if (tracks_q > TRK_W'(MAX_TRACKS)) begin
      cfg.ntr = TRK_W'(MAX_TRACKS);
    end
    cfg.ncar = cars_q;
    if (cars_q == '0) begin
      cfg.ncar = CAR_W'(1);
    end else if (cars_q > CAR_W'(MAX_CARS)) begin
      cfg.ncar = CAR_W'(MAX_CARS);
    end
  end

  rcr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .item_i          (item_i),
    .cfg_i           (cfg),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata)
  );

  rcr_track_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  `RCR_ASSERT(a_accept_goes_busy, start && !busy |=> busy, "accepted car did not raise busy")
  `RCR_ASSERT(a_idle_beat_is_last, result_strobe_o && !busy |-> result_o.last, "non-final beat while idle")
  `RCR_ASSERT(a_error_beat_form, result_strobe_o && result_o.status != STAT_MOVED |-> result_o.moved_car == '0 && result_o.last, "malformed error beat")
  `RCR_ASSERT(a_release_to_output, result_strobe_o && result_o.from_track != '0 |-> result_o.to_track == '0 && result_o.moved_car != '0, "release beat not to output")
  `RCR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !busy && !result_strobe_o, "activity during reset")

endmodule

/* sim/tb_railroad_car_rearranger.sv */
// ---------------------------------------------------------------------------
// Railroad car rearranger testbench
// Feeds car sequences through the command port, predicts every move record
// from an internal copy of the holding tracks and checks each record beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_railroad_car_rearranger;
  import rcr_pkg::*;

  localparam int NO_CAR = MAX_CARS + 2;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_CARS = 16;
  localparam int PH_TRK [NUM_PHASES] = '{127, 0, 2, 4, 8, 5, 1, 15, 3};
  localparam int PH_CAR [NUM_PHASES] = '{127, 0, 10, 16, 64, 30, 6, 3, 64};

  // Holds the yard state and the move records still due from the block.
  class shunt_board;
    int unsigned errors;
    rcr_out_t    moves_due[$];
    int          tracks_reg;
    int          cars_reg;
    int          next_car;
    int          low_car;
    int          low_track;
    bit          failed;
    int          fill[MAX_TRACKS];
    int          stack[MAX_TRACKS][MAX_CARS];

    function new();
      tracks_reg = 3;
      cars_reg   = 64;
      clear_yard();
    endfunction

    function void clear_yard();
      foreach (fill[t]) fill[t] = 0;
      next_car  = 1;
      low_car   = NO_CAR;
      low_track = 0;
      failed    = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAR_W-1:0] v);
      if (idx == CFG_TRACKS) tracks_reg = int'(v[TRK_W-1:0]);
      else cars_reg = int'(v);
    endfunction

    function int eff_tracks();
      if (tracks_reg < 1) return 1;
      if (tracks_reg > MAX_TRACKS) return MAX_TRACKS;
      return tracks_reg;
    endfunction

    function int eff_cars();
      if (cars_reg < 1) return 1;
      if (cars_reg > MAX_CARS) return MAX_CARS;
      return cars_reg;
    endfunction

    function int pending();
      return moves_due.size();
    endfunction

    function void add_move(int car, int from, int to, rcr_status_e st);
      rcr_out_t r;
      r.moved_car  = CAR_W'(car);
      r.from_track = TRK_W'(from);
      r.to_track   = TRK_W'(to);
      r.status     = st;
      r.last       = 1'b0;
      moves_due.push_back(r);
    endfunction

    // Find the smallest car on top of any track, all tracks included.
    function void rescan();
      low_car   = NO_CAR;
      low_track = 0;
      for (int t = 0; t < MAX_TRACKS; t++) begin
        if (fill[t] > 0 && stack[t][fill[t]-1] < low_car) begin
          low_car   = stack[t][fill[t]-1];
          low_track = t + 1;
        end
      end
    endfunction

    function void note_car(rcr_in_t it);
      int car, ntr, ncar, k, best, best_top, tp, i;
      car  = int'(it.car);
      ntr  = eff_tracks();
      ncar = eff_cars();
      k    = 0;
      if (it.new_sequence) clear_yard();
      if (failed) begin
        add_move(0, 0, 0, STAT_FAILED);
      end else if (car == 0 || car > ncar || car < next_car) begin
        add_move(0, 0, 0, STAT_RANGE);
      end else if (car == next_car) begin
        add_move(car, 0, 0, STAT_MOVED);
        k = 1;
        next_car++;
        while (k < MAX_CARS && low_car == next_car && low_track >= 1 &&
               low_track <= MAX_TRACKS && fill[low_track-1] > 0) begin
          fill[low_track-1]--;
          add_move(low_car, low_track, 0, STAT_MOVED);
          k++;
          next_car++;
          rescan();
        end
      end else begin
        best     = 0;
        best_top = NO_CAR;
        // An empty track is taken only if no track with a fitting top turns up.
        for (int t = 0; t < ntr; t++) begin
          if (fill[t] > 0) begin
            tp = stack[t][fill[t]-1];
            if (car < tp && tp < best_top && fill[t] < MAX_CARS) begin
              best_top = tp;
              best     = t + 1;
            end
          end else if (best == 0) begin
            best = t + 1;
          end
        end
        if (best == 0) begin
          failed = 1'b1;
          add_move(0, 0, 0, STAT_NO_TRACK);
        end else begin
          i = best - 1;
          stack[i][fill[i]] = car;
          fill[i]++;
          if (car < low_car) begin
            low_car   = car;
            low_track = best;
          end
          add_move(car, 0, best, STAT_MOVED);
        end
      end
      moves_due[moves_due.size()-1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_move(rcr_out_t got);
      rcr_out_t want;
      if (moves_due.size() == 0) begin
        report($sformatf("record with none due: car %0d from %0d to %0d status %0d",
                         got.moved_car, got.from_track, got.to_track, got.status));
        return;
      end
      want = moves_due.pop_front();
      if (got.moved_car !== want.moved_car)
        report($sformatf("moved_car %0d, want %0d", got.moved_car, want.moved_car));
      if (got.from_track !== want.from_track)
        report($sformatf("from_track %0d, want %0d", got.from_track, want.from_track));
      if (got.to_track !== want.to_track)
        report($sformatf("to_track %0d, want %0d", got.to_track, want.to_track));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b (car %0d)", got.last, want.last,
                         want.moved_car));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  rcr_in_t              item_i;
  logic                 result_strobe_o;
  rcr_out_t             result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CAR_W-1:0]     cfg_wdata_i;

  shunt_board sb;
  bit         burst;

  railroad_car_rearranger dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o === 1'b1) sb.check_move(result_o);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (burst || r < 10) return 0;
    if (r < 16) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  // Hold start until the beat is taken, then idle for the given gap.
  task automatic send_car(input int car, input bit ns, input int gap);
    rcr_in_t it;
    it.car          = CAR_W'(car);
    it.new_sequence = ns;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_car(it);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CAR_W'(v);
    @(posedge clk_i);
    sb.write_reg(idx, CAR_W'(v));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every due record and an idle block.
  task automatic drain();
    int cnt;
    cnt = 0;
    start <= 1'b0;
    while ((sb.pending() != 0 || busy !== 1'b0) && cnt < 5000) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_sequence(inout int sent);
    int n, kind, len, b, i, j, tmp, w;
    int perm[MAX_CARS];
    n     = sb.eff_cars();
    kind  = $urandom_range(0, 9);
    burst = ($urandom_range(0, 3) == 0);
    if (kind == 9) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++)
        send_car($urandom_range(0, 127), $urandom_range(0, 3) == 0, pick_gap());
      sent += len;
      return;
    end
    for (i = 0; i < n; i++) perm[i] = i + 1;
    if (kind <= 4 || kind == 8) begin
      // reverse short blocks: each block stacks on one track and drains in order
      i = 0;
      while (i < n) begin
        b = $urandom_range(1, 6);
        if (i + b > n) b = n - i;
        for (j = 0; j < b / 2; j++) begin
          tmp = perm[i+j];
          perm[i+j] = perm[i+b-1-j];
          perm[i+b-1-j] = tmp;
        end
        i += b;
      end
      if (kind == 8) begin
        j = $urandom_range(0, n - 1);
        perm[j] = $urandom_range(0, 1) ? $urandom_range(0, 127)
                                       : perm[$urandom_range(0, n - 1)];
      end
    end else if (kind <= 6) begin
      w = sb.eff_tracks();
      for (i = 0; i < n; i++) begin
        j = i + $urandom_range(0, w);
        if (j >= n) j = n - 1;
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
    end else begin
      for (i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
    end
    len = n;
    if ($urandom_range(0, 4) == 0) len = $urandom_range(1, n);
    for (i = 0; i < len; i++) send_car(perm[i], i == 0, pick_gap());
    sent += len;
  endtask

  initial begin
    int sent;
    sb          = new();
    burst       = 1'b0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_TRACKS;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range errors, parking, release chains, failure and clear.
    send_car(1, 1'b1, pick_gap());
    send_car(0, 1'b0, pick_gap());
    send_car(65, 1'b0, pick_gap());
    send_car(1, 1'b0, pick_gap());
    send_car(5, 1'b0, pick_gap());
    send_car(4, 1'b0, pick_gap());
    send_car(7, 1'b0, pick_gap());
    send_car(6, 1'b0, pick_gap());
    send_car(9, 1'b0, pick_gap());
    drain();
    // Lower the track count mid-sequence: car 10 finds no track, later cars fail until the clear.
    cfg_write(CFG_TRACKS, 1);
    send_car(2, 1'b0, pick_gap());
    send_car(10, 1'b0, pick_gap());
    send_car(11, 1'b0, pick_gap());
    send_car(8, 1'b0, pick_gap());
    send_car(0, 1'b1, pick_gap());
    drain();
    cfg_write(CFG_TRACKS, 8);
    send_car(3, 1'b0, pick_gap());
    send_car(3, 1'b0, pick_gap());
    send_car(64, 1'b0, pick_gap());
    send_car(1, 1'b0, pick_gap());
    send_car(2, 1'b0, pick_gap());
    send_car(127, 1'b0, pick_gap());
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_write(CFG_TRACKS, PH_TRK[p]);
      cfg_write(CFG_CARS, PH_CAR[p]);
      sent = 0;
      while (sent < PHASE_CARS) run_sequence(sent);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d records never arrived", sb.pending()));
    if (sb.errors == 0) $display("tb_railroad_car_rearranger: clean");
    else $display("tb_railroad_car_rearranger: errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_railroad_car_rearranger: errors");
    $finish;
  end

endmodule
